// ===== rtl/crcfd_pkg.sv =====
// Shared constants and types of the CRC-checked frame deframer.
// Used by the CRC unit, the top level and the bench helper package.
package crcfd_pkg;

    localparam int C_PAYLOAD_LEN = 16;

    localparam logic [7:0]  C_HDR0     = 8'hAA;
    localparam logic [7:0]  C_HDR1     = 8'hBB;
    localparam logic [15:0] C_CRC_INIT = 16'hFFFF;
    localparam logic [15:0] C_CRC_POLY = 16'hA001;

    typedef enum logic [1:0] {
        KIND_PAYLOAD    = 2'd0,
        KIND_BAD_FOOTER = 2'd1,
        KIND_BAD_CRC    = 2'd2
    } t_kind;

    typedef struct packed {
        logic init;
        logic load;
        logic step;
    } t_crc_ctrl;

endpackage

// ===== rtl/crcfd_crc.sv =====
// Bit-serial CRC-16 (reflected, 0xA001): one shift per cycle while stepped.
// Depends on crcfd_pkg for the control struct and the CRC constants.
module crcfd_crc (
    input  logic                i_clk,
    input  crcfd_pkg::t_crc_ctrl i_ctrl,
    input  logic [7:0]          i_byte,
    output logic [15:0]         o_crc
);
    import crcfd_pkg::*;

    logic [15:0] r_crc;
    logic [15:0] n_crc;

    always_comb begin
        n_crc = r_crc;
        if (i_ctrl.init) begin
            n_crc = C_CRC_INIT;
        end else if (i_ctrl.load) begin
            n_crc = r_crc ^ {8'h00, i_byte};
        end else if (i_ctrl.step) begin
            n_crc = r_crc[0] ? ((r_crc >> 1) ^ C_CRC_POLY) : (r_crc >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc <= n_crc;
    end

    assign o_crc = r_crc;

endmodule

// ===== rtl/crcfd_ring.sv =====
// Frame byte store: one write port, one read port with registered data.
// No package dependency; depth and address width come from the top level.
module crcfd_ring #(
    parameter int DEPTH = 22,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/crc_checked_frame_deframer.sv =====
// Frame deframer: 0xAA 0xBB, PAYLOAD_LEN bytes, CRC-16 (low byte first), 0xBB 0xAA.
// A byte that completes no frame leaves the deframer ready; the next byte is taken in the next cycle.
// A byte that fills a frame starts a check pass over the stored bytes through the
// bit-serial CRC unit; then a good frame emits its payload items one at a time (when
// the output side takes them), and a bad frame emits a single error item.
// Reset (synchronous, active low) empties the store; its contents need no clearing.
module crc_checked_frame_deframer #(
    parameter int PAYLOAD_LEN = crcfd_pkg::C_PAYLOAD_LEN
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_data_byte,
    output logic       o_last
);
    import crcfd_pkg::*;

    localparam int F  = PAYLOAD_LEN + 6;
    localparam int CW = $clog2(F + 1);
    localparam int AW = $clog2(F);

    localparam logic [CW-1:0] L_ONE     = CW'(1);
    localparam logic [CW-1:0] L_FIRST   = CW'(2);
    localparam logic [CW-1:0] L_PAY_END = CW'(PAYLOAD_LEN + 1);
    localparam logic [CW-1:0] L_CRC_LO  = CW'(PAYLOAD_LEN + 2);
    localparam logic [CW-1:0] L_CRC_HI  = CW'(PAYLOAD_LEN + 3);
    localparam logic [CW-1:0] L_FOOT0   = CW'(PAYLOAD_LEN + 4);
    localparam logic [CW-1:0] L_FOOT1   = CW'(PAYLOAD_LEN + 5);
    localparam logic [CW-1:0] L_FULL    = CW'(F);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RD   = 7'b0000010,
        S_LD   = 7'b0000100,
        S_CRC  = 7'b0001000,
        S_DEC  = 7'b0010000,
        S_ERD  = 7'b0100000,
        S_ELD  = 7'b1000000
    } t_state;

    // logical position -> ring address
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] base,
                                             input logic [CW-1:0] lidx);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(lidx);
        if (sum >= (CW+1)'(F)) begin
            sum = sum - (CW+1)'(F);
        end
        return sum[AW-1:0];
    endfunction

    t_state        r_state, n_state;
    logic [CW-1:0] r_fill, n_fill;
    logic [AW-1:0] r_base, n_base;
    logic [CW-1:0] r_idx, n_idx;
    logic [2:0]    r_bit, n_bit;
    logic          r_found, n_found;
    logic [CW-1:0] r_jpos, n_jpos;
    logic          r_foot_ok, n_foot_ok;
    logic [15:0]   r_rx_crc, n_rx_crc;
    logic [7:0]    r_prev, n_prev;
    logic          r_ov, n_ov;
    t_kind         r_okind, n_okind;
    logic [7:0]    r_odata, n_odata;
    logic          r_olast, n_olast;

    logic          in_acc;
    logic          slot_free;
    logic          wr_en;
    logic [7:0]    rd_data;
    logic [15:0]   crc;
    t_crc_ctrl     crc_ctrl;

    assign o_ready   = (r_state == S_IDLE);
    assign in_acc    = i_valid && o_ready;
    assign slot_free = !r_ov || i_ready;

    always_comb begin
        if (r_fill == '0) begin
            wr_en = in_acc && (i_rx_byte == C_HDR0);
        end else if (r_fill == L_ONE) begin
            wr_en = in_acc && (i_rx_byte == C_HDR1);
        end else begin
            wr_en = in_acc;
        end
    end

    crcfd_ring #(
        .DEPTH (F),
        .AW    (AW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (f_phys(r_base, r_fill)),
        .i_wr_data (i_rx_byte),
        .i_rd_addr (f_phys(r_base, r_idx)),
        .o_rd_data (rd_data)
    );

    crcfd_crc u_crc (
        .i_clk  (i_clk),
        .i_ctrl (crc_ctrl),
        .i_byte (rd_data),
        .o_crc  (crc)
    );

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_base    = r_base;
        n_idx     = r_idx;
        n_bit     = r_bit;
        n_found   = r_found;
        n_jpos    = r_jpos;
        n_foot_ok = r_foot_ok;
        n_rx_crc  = r_rx_crc;
        n_prev    = r_prev;
        n_ov      = r_ov && !i_ready;
        n_okind   = r_okind;
        n_odata   = r_odata;
        n_olast   = r_olast;
        crc_ctrl  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (r_fill == '0) begin
                        n_fill = (i_rx_byte == C_HDR0) ? L_ONE : '0;
                    end else if (r_fill == L_ONE) begin
                        // a repeated 0xAA stays the lone header start
                        if (i_rx_byte == C_HDR1) begin
                            n_fill = CW'(2);
                        end else if (i_rx_byte != C_HDR0) begin
                            n_fill = '0;
                        end
                    end else begin
                        n_fill = r_fill + L_ONE;
                        if (r_fill + L_ONE == L_FULL) begin
                            n_state       = S_RD;
                            n_idx         = L_FIRST;
                            n_found       = 1'b0;
                            n_foot_ok     = 1'b1;
                            crc_ctrl.init = 1'b1;
                        end
                    end
                end
            end
            S_RD: begin
                n_state = S_LD;
            end
            S_LD: begin
                // track the first header after the dropped one
                if (!r_found && r_idx > L_FIRST && r_prev == C_HDR0 &&
                    rd_data == C_HDR1) begin
                    n_found = 1'b1;
                    n_jpos  = r_idx - L_ONE;
                end
                n_prev = rd_data;
                if (r_idx <= L_PAY_END) begin
                    crc_ctrl.load = 1'b1;
                    n_bit         = '0;
                    n_state       = S_CRC;
                end else begin
                    if (r_idx == L_CRC_LO) begin
                        n_rx_crc[7:0] = rd_data;
                    end else if (r_idx == L_CRC_HI) begin
                        n_rx_crc[15:8] = rd_data;
                    end else if (r_idx == L_FOOT0) begin
                        n_foot_ok = r_foot_ok && (rd_data == C_HDR1);
                    end else begin
                        n_foot_ok = r_foot_ok && (rd_data == C_HDR0);
                    end
                    if (r_idx == L_FOOT1) begin
                        // keep a trailing 0xAA as a header start
                        if (!n_found && rd_data == C_HDR0) begin
                            n_found = 1'b1;
                            n_jpos  = L_FOOT1;
                        end
                        n_state = S_DEC;
                    end else begin
                        n_idx   = r_idx + L_ONE;
                        n_state = S_RD;
                    end
                end
            end
            S_CRC: begin
                crc_ctrl.step = 1'b1;
                n_bit         = r_bit + 3'd1;
                if (r_bit == 3'd7) begin
                    n_idx   = r_idx + L_ONE;
                    n_state = S_RD;
                end
            end
            S_DEC: begin
                if (slot_free) begin
                    if (!r_foot_ok || crc != r_rx_crc) begin
                        n_ov    = 1'b1;
                        n_okind = r_foot_ok ? KIND_BAD_CRC : KIND_BAD_FOOTER;
                        n_odata = '0;
                        n_olast = 1'b1;
                        if (r_found) begin
                            n_base = f_phys(r_base, r_jpos);
                            n_fill = L_FULL - r_jpos;
                        end else begin
                            n_fill = '0;
                        end
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = L_FIRST;
                        n_state = S_ERD;
                    end
                end
            end
            S_ERD: begin
                n_state = S_ELD;
            end
            S_ELD: begin
                // hold the read address until the output slot frees
                if (slot_free) begin
                    n_ov    = 1'b1;
                    n_okind = KIND_PAYLOAD;
                    n_odata = rd_data;
                    n_olast = (r_idx == L_PAY_END);
                    if (r_idx == L_PAY_END) begin
                        n_fill  = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + L_ONE;
                        n_state = S_ERD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_base  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_base  <= n_base;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_bit     <= n_bit;
        r_found   <= n_found;
        r_jpos    <= n_jpos;
        r_foot_ok <= n_foot_ok;
        r_rx_crc  <= n_rx_crc;
        r_prev    <= n_prev;
        r_okind   <= n_okind;
        r_odata   <= n_odata;
        r_olast   <= n_olast;
    end

    assign o_valid     = r_ov;
    assign o_kind      = r_okind;
    assign o_data_byte = r_odata;
    assign o_last      = r_olast;

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= L_FULL)
        else $error("fill count beyond a frame");

    a_base_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_base < AW'(F) || F == (1 << AW))
        else $error("ring base out of range");

    a_crc_in_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CRC) |-> (r_idx >= L_FIRST && r_idx <= L_PAY_END))
        else $error("CRC step outside payload");

    a_err_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind != KIND_PAYLOAD) |-> (o_last && o_data_byte == 8'h00))
        else $error("error item not a single zeroed last item");

    a_check_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LD || r_state == S_CRC || r_state == S_DEC) |-> (r_fill == L_FULL))
        else $error("check pass without a full frame");

endmodule

// ===== tb/sv/crcfd_tb_pkg.sv =====
// Result tracker and frame helpers for the CRC-checked frame deframer bench.
// Depends on crcfd_pkg for the payload length, header bytes, CRC constants and result kinds.
package crcfd_tb_pkg;
    import crcfd_pkg::*;

    localparam int FRAME_BYTES = C_PAYLOAD_LEN + 6;

    typedef logic [7:0] t_payload [C_PAYLOAD_LEN];

    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_CRC,
        FRAME_BAD_FOOTER,
        FRAME_CUT
    } t_frame_fault;

    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES,
        FILL_NESTED
    } t_payload_fill;

    typedef struct {
        t_kind      kind;
        logic [7:0] data_byte;
        logic       last;
    } t_deframed;

    function automatic logic [15:0] modbus_crc(input t_payload body);
        logic [15:0] crc;
        crc = C_CRC_INIT;
        for (int i = 0; i < C_PAYLOAD_LEN; i++) begin
            crc = crc ^ {8'h00, body[i]};
            for (int b = 0; b < 8; b++) begin
                crc = crc[0] ? ((crc >> 1) ^ C_CRC_POLY) : (crc >> 1);
            end
        end
        return crc;
    endfunction

    class deframer_scoreboard;
        logic [7:0] held_bytes [FRAME_BYTES];
        int         held;
        t_deframed  deframed_items [$];
        int         mismatches;

        function new();
            held = 0;
            mismatches = 0;
        endfunction

        // Keep the first header, or a trailing 0xAA, at the front; drop what precedes it.
        function void realign();
            int start;
            start = held;
            for (int i = 0; i < held; i++) begin
                if (start == held && held_bytes[i] == C_HDR0 &&
                    (i + 1 == held || held_bytes[i + 1] == C_HDR1)) begin
                    start = i;
                end
            end
            for (int i = 0; i < held - start; i++) begin
                held_bytes[i] = held_bytes[i + start];
            end
            held = held - start;
        endfunction

        function void drop_header();
            for (int i = 0; i < held - 2; i++) begin
                held_bytes[i] = held_bytes[i + 2];
            end
            held = held - 2;
            realign();
        endfunction

        function void note_rx_byte(input logic [7:0] rx);
            t_payload    body;
            logic [15:0] sent_crc;
            t_deframed   item;
            if (held >= FRAME_BYTES) begin
                held = 0;
            end
            held_bytes[held] = rx;
            held++;
            realign();
            if (held < FRAME_BYTES) begin
                return;
            end
            for (int i = 0; i < C_PAYLOAD_LEN; i++) begin
                body[i] = held_bytes[2 + i];
            end
            sent_crc = {held_bytes[C_PAYLOAD_LEN + 3], held_bytes[C_PAYLOAD_LEN + 2]};
            item.data_byte = 8'h00;
            item.last = 1'b1;
            // footer is judged before the checksum
            if (held_bytes[C_PAYLOAD_LEN + 4] != C_HDR1 ||
                held_bytes[C_PAYLOAD_LEN + 5] != C_HDR0) begin
                item.kind = KIND_BAD_FOOTER;
                deframed_items = {deframed_items, item};
                drop_header();
            end else if (sent_crc != modbus_crc(body)) begin
                item.kind = KIND_BAD_CRC;
                deframed_items = {deframed_items, item};
                drop_header();
            end else begin
                for (int i = 0; i < C_PAYLOAD_LEN; i++) begin
                    item.kind = KIND_PAYLOAD;
                    item.data_byte = body[i];
                    item.last = (i == C_PAYLOAD_LEN - 1);
                    deframed_items = {deframed_items, item};
                end
                held = 0;
            end
        endfunction

        function void check_result(input logic [1:0] kind, input logic [7:0] data_byte,
                                   input logic last);
            t_deframed want;
            if (deframed_items.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected item: kind %0d data %02h last %0d",
                             kind, data_byte, last);
                end
                return;
            end
            want = deframed_items.pop_front();
            if (kind !== want.kind || data_byte !== want.data_byte || last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("item mismatch: expected %0d/%02h/%0d, got %0d/%02h/%0d",
                             want.kind, want.data_byte, want.last, kind, data_byte, last);
                end
            end
        endfunction

        function int outstanding();
            return deframed_items.size();
        endfunction

        function void report_leftovers();
            if (deframed_items.size() != 0) begin
                $display("%0d expected items never arrived", deframed_items.size());
                mismatches += deframed_items.size();
            end
        endfunction
    endclass

endpackage

// ===== tb/sv/crc_checked_frame_deframer_tb.sv =====
// Top-level bench for crc_checked_frame_deframer: random frames, faults and noise.
// Depends on crcfd_pkg and crcfd_tb_pkg (tracker class, CRC helper, frame enums).
module crc_checked_frame_deframer_tb;
    import crcfd_pkg::*;
    import crcfd_tb_pkg::*;

    localparam int QUIET_LIMIT     = 4000;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int DRAIN_CYCLES    = 400;
    localparam int RANDOM_ITEMS    = 260;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_ready = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [1:0] o_kind;
    logic [7:0] o_data_byte;
    logic       o_last;

    deframer_scoreboard frame_sb = new();

    bit calm = 1'b0;
    int hold_request = 0;
    int items_sent = 0;

    crc_checked_frame_deframer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_rx_byte   (i_rx_byte),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_kind      (o_kind),
        .o_data_byte (o_data_byte),
        .o_last      (o_last)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            frame_sb.note_rx_byte(i_rx_byte);
        end
        if (i_rst_n && o_valid && i_ready) begin
            frame_sb.check_result(o_kind, o_data_byte, o_last);
        end
    end

    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else begin
                i_ready <= calm || ($urandom_range(0, 99) >= 36);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    task automatic send_byte(input logic [7:0] rx);
        while (!calm && $urandom_range(0, 99) < 36) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_rx_byte <= rx;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    task automatic send_frame(input t_frame_fault fault, input t_payload_fill fill);
        t_payload    body;
        logic [7:0]  frame [FRAME_BYTES];
        logic [15:0] crc;
        int          spot;
        int          count;
        for (int i = 0; i < C_PAYLOAD_LEN; i++) begin
            case (fill)
                FILL_ZERO: body[i] = 8'h00;
                FILL_ONES: body[i] = 8'hFF;
                default:   body[i] = 8'($urandom);
            endcase
        end
        // plant a header inside the payload so a rejected frame rescans into it
        if (fill == FILL_NESTED) begin
            spot = $urandom_range(0, C_PAYLOAD_LEN - 2);
            body[spot] = C_HDR0;
            body[spot + 1] = C_HDR1;
        end
        crc = modbus_crc(body);
        if (fault == FRAME_BAD_CRC) begin
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        end
        frame[0] = C_HDR0;
        frame[1] = C_HDR1;
        for (int i = 0; i < C_PAYLOAD_LEN; i++) begin
            frame[2 + i] = body[i];
        end
        frame[C_PAYLOAD_LEN + 2] = crc[7:0];
        frame[C_PAYLOAD_LEN + 3] = crc[15:8];
        frame[C_PAYLOAD_LEN + 4] = C_HDR1;
        frame[C_PAYLOAD_LEN + 5] = C_HDR0;
        if (fault == FRAME_BAD_FOOTER) begin
            spot = $urandom_range(C_PAYLOAD_LEN + 4, C_PAYLOAD_LEN + 5);
            frame[spot] = frame[spot] ^ 8'($urandom_range(1, 255));
        end
        count = (fault == FRAME_CUT) ? $urandom_range(1, FRAME_BYTES - 1) : FRAME_BYTES;
        for (int i = 0; i < count; i++) begin
            send_byte(frame[i]);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (frame_sb.outstanding() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin : stimulus
        t_frame_fault  fault;
        t_payload_fill fill;
        int            frame_no;
        int            start;
        int            pick;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // noise, then two repeated 0xAA bytes ahead of a good frame
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(C_HDR1);
        send_byte(8'h55);
        send_byte(C_HDR0);
        send_byte(C_HDR0);
        send_frame(FRAME_GOOD, FILL_ONES);

        frame_no = 0;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            if (frame_no == 4) begin
                hold_request = HOLD_OFF_CYCLES;
            end
            calm = (frame_no >= 6 && frame_no < 9);
            if (frame_no == 9) begin
                wait_drained();
            end

            pick = $urandom_range(0, 99);
            if (frame_no < 4) begin
                fault = t_frame_fault'(frame_no);
            end else if (frame_no < 6) begin
                fault = FRAME_GOOD;
            end else if (pick < 55) begin
                fault = FRAME_GOOD;
            end else if (pick < 70) begin
                fault = FRAME_BAD_CRC;
            end else if (pick < 82) begin
                fault = FRAME_BAD_FOOTER;
            end else begin
                fault = FRAME_CUT;
            end

            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                fill = FILL_ZERO;
            end else if (pick < 20) begin
                fill = FILL_ONES;
            end else if (pick < 40) begin
                fill = FILL_NESTED;
            end else begin
                fill = FILL_RANDOM;
            end

            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    send_byte(($urandom_range(0, 3) == 0) ? C_HDR0 : 8'($urandom));
                end
            end
            send_frame(fault, fill);
            frame_no++;
        end

        calm = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        frame_sb.report_leftovers();
        if (frame_sb.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
